@@ rtl/core/kwm_pkg.sv @@
// ---------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way key/value pair merge.
// ---------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_RUNS    = 64;
    localparam int RUN_FIELD   = 64;                  // runs a 6-bit index can name
    localparam int RUN_LIM     = (MAX_RUNS < RUN_FIELD) ? MAX_RUNS : RUN_FIELD;
    localparam int IDX_W       = $clog2(MAX_RUNS);
    localparam int CNT_W       = $clog2(MAX_RUNS + 1);
    localparam int RUN_W       = 6;
    localparam int CFG_W       = 7;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SUPPLY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [RUN_W-1:0] run_index;
        logic             run_empty;
        logic [KEY_W-1:0] head_key;
        logic [VAL_W-1:0] head_value;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [VAL_W-1:0] out_value;
        logic [RUN_W-1:0] from_run;
        logic             done_res;
        logic [63:0]      total_written;
    } t_res;

    // Head store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_head_wr;

    // Outcome of one minimum scan
    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_scan_res;

endpackage

@@ rtl/core/kwm_scan.sv @@
// ---------------------------------------------------------------------------
// kwm_scan
// Head store and minimum search: one read and one 128-bit compare a cycle.
// ---------------------------------------------------------------------------
module kwm_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kwm_pkg::t_head_wr         i_wr,
    input  logic                      i_go,
    input  logic [kwm_pkg::MAX_RUNS-1:0] i_present,
    output kwm_pkg::t_scan_res        o_res
);
    import kwm_pkg::*;

    logic [KEY_W+VAL_W-1:0] r_mem [MAX_RUNS];

    logic                   r_active;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [KEY_W+VAL_W-1:0] r_rd_data;
    logic                   r_found;
    logic                   r_done;
    logic [IDX_W-1:0]       r_best_idx;
    logic [KEY_W+VAL_W-1:0] r_best;

    logic                   last_read;
    logic                   take;

    assign last_read = (r_cnt == CNT_W'(MAX_RUNS));
    // strict less keeps the lower run on an exact tie, scan runs upward
    assign take = r_rd_vld && i_present[r_rd_idx] && (!r_found || (r_rd_data < r_best));

    // head store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= {i_wr.key, i_wr.value};
        end
        r_rd_data <= r_mem[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else if (r_active) begin
                if (take) begin
                    r_found <= 1'b1;
                end
                if (last_read) begin
                    r_active <= 1'b0;
                    r_rd_vld <= 1'b0;
                    r_done   <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b1;
                    r_cnt    <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (take) begin
            r_best_idx <= r_rd_idx;
            r_best     <= r_rd_data;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.idx   = r_best_idx;
    assign o_res.key   = r_best[KEY_W+VAL_W-1:VAL_W];
    assign o_res.value = r_best[VAL_W-1:0];

endmodule

@@ rtl/core/k_way_pair_merge.sv @@
// ---------------------------------------------------------------------------
// k_way_pair_merge
// Merges up to 64 sorted key/value runs into one ascending stream.
// ---------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. A start
// request (op 0) clears all heads and marks runs 0..runs_in_use-1 as
// awaited; it gives no result. Each awaited run then supplies its head, or
// an empty mark (op 1). Supplies for runs not awaited are dropped silently.
// When the last awaited head arrives the block goes busy and searches the
// head store for the smallest pair (key, then value, then lower run). The
// search reads one head a cycle from a store with separate write and read
// ports through one 128-bit comparator; the result strobe rises in the
// same cycle that busy drops. A pair result names the
// run that must supply next; once no head remains a done result carries
// the pair count. o_res_valid is high for one cycle only and cannot be
// held off: the receiver must take every result as it comes. A new
// request may be issued in the cycle the result is shown.
// runs_in_use is sampled at each start; 0 acts as 1, above 64 saturates.
// ---------------------------------------------------------------------------
module k_way_pair_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  kwm_pkg::t_req           i_req,
    input  logic                    i_cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                    o_res_valid,
    output kwm_pkg::t_res           o_res
);
    import kwm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_cfg_runs;
    logic [MAX_RUNS-1:0]   r_present;
    logic [MAX_RUNS-1:0]   r_awaiting;
    logic [CNT_W-1:0]      r_awaited;
    logic [63:0]           r_pairs;
    logic                  r_res_valid;
    t_res                  r_res;

    logic                  accept;
    logic [IDX_W-1:0]      sup_idx;
    logic                  in_range;
    logic                  supply_ok;
    logic [CNT_W-1:0]      awaited_dec;
    logic                  go;
    logic [7:0]            eff_runs;
    t_head_wr              head_wr;
    t_scan_res             scan;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign sup_idx  = IDX_W'(i_req.run_index);
    assign in_range = (32'(i_req.run_index) < MAX_RUNS);
    assign supply_ok = accept && (i_req.op == OP_SUPPLY) && in_range && r_awaiting[sup_idx];
    assign awaited_dec = (r_awaited != '0) ? (r_awaited - CNT_W'(1)) : '0;
    // last awaited head in: kick off the search
    assign go = supply_ok && (awaited_dec == '0);

    // run count as used by a start, clamped to the legal range
    always_comb begin
        eff_runs = (r_cfg_runs == '0) ? 8'd1 : 8'(r_cfg_runs);
        if (eff_runs > 8'(RUN_LIM)) begin
            eff_runs = 8'(RUN_LIM);
        end
    end

    assign head_wr.en    = supply_ok && !i_req.run_empty;
    assign head_wr.idx   = sup_idx;
    assign head_wr.key   = i_req.head_key;
    assign head_wr.value = i_req.head_value;

    kwm_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (head_wr),
        .i_go      (go),
        .i_present (r_present),
        .o_res     (scan)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_runs  <= CFG_W'(64);
            r_present   <= '0;
            r_awaiting  <= '0;
            r_awaited   <= '0;
            r_pairs     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cfg_runs <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_req.op == OP_START)) begin
                        r_present <= '0;
                        for (int i = 0; i < MAX_RUNS; i++) begin
                            r_awaiting[i] <= (i < int'(eff_runs));
                        end
                        r_awaited <= CNT_W'(eff_runs);
                        r_pairs   <= '0;
                    end else if (supply_ok) begin
                        r_awaiting[sup_idx] <= 1'b0;
                        r_awaited           <= awaited_dec;
                        if (!i_req.run_empty) begin
                            r_present[sup_idx] <= 1'b1;
                        end
                        if (go) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan.done) begin
                        r_res_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (scan.found) begin
                            // winner leaves the heads; its run supplies next
                            r_present[scan.idx]  <= 1'b0;
                            r_awaiting[scan.idx] <= 1'b1;
                            r_awaited            <= CNT_W'(1);
                            r_pairs              <= r_pairs + 64'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && scan.done) begin
            if (scan.found) begin
                r_res.out_key       <= scan.key;
                r_res.out_value     <= scan.value;
                r_res.from_run      <= RUN_W'(scan.idx);
                r_res.done_res      <= 1'b0;
                r_res.total_written <= '0;
            end else begin
                r_res.out_key       <= '0;
                r_res.out_value     <= '0;
                r_res.from_run      <= '0;
                r_res.done_res      <= 1'b1;
                r_res.total_written <= r_pairs;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // awaited count tracks the awaiting flags
    a_await_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_awaiting) == int'(r_awaited))
        else $error("awaited count out of step with awaiting flags");

    // nothing is awaited while a search runs
    a_scan_no_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_awaited == '0))
        else $error("search running with heads still awaited");

    // heads must not move under a running search
    a_scan_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && $past(r_state == ST_SCAN)) |-> $stable(r_present))
        else $error("head flags changed during search");

    // the end of a search is followed by a result and a return to idle
    a_res_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && scan.done |=> o_res_valid && (r_state == ST_IDLE))
        else $error("search end without result strobe");

endmodule
